// ===== src/bhd_pkg.sv =====
`default_nettype none

package bhd_pkg;

    localparam int NODE_LIMIT_DEF = 64;
    localparam int NODE_W         = 6;
    localparam int HOP_W          = 7;
    localparam int COUNT_W        = 7;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic [HOP_W-1:0]   HOP_UNREACHED  = 7'h7F;
    localparam logic [HOP_W-1:0]   HOP_ZERO       = 7'd0;
    localparam logic [HOP_W-1:0]   HOP_STEP       = 7'd1;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WA,
        ST_EDGE_WB,
        ST_START,
        ST_DEQ,
        ST_ROW,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic accept;
        logic edge_rd_a;
        logic edge_wr_a;
        logic edge_wr_b;
        logic start;
        logic deq;
        logic row_rd;
        logic scan;
        logic emit_rd;
        logic emit_ld;
        logic idx_clr;
        logic idx_inc;
    } cmd_t;

    typedef struct packed {
        logic in_kind;
        logic in_edge_ok;
        logic start_ok;
        logic queue_nonempty;
        logic idx_last;
        logic count_zero;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/bhd_ram.sv =====
`default_nettype none

module bhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bhd_ctrl.sv =====
`default_nettype none

module bhd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire bhd_pkg::sts_t sts,
    output bhd_pkg::cmd_t      cmd
);

    import bhd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.in_kind == KIND_SEARCH)
                    begin
                        state_next = ST_START;
                    end
                    else if (sts.in_edge_ok)
                    begin
                        state_next = ST_EDGE_RD;
                    end
                end
            end
            ST_EDGE_RD: state_next = ST_EDGE_WA;
            ST_EDGE_WA: state_next = ST_EDGE_WB;
            ST_EDGE_WB: state_next = ST_IDLE;
            ST_START:
            begin
                if (sts.start_ok)
                begin
                    state_next = ST_DEQ;
                end
                else if (sts.count_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_DEQ:
            begin
                if (sts.queue_nonempty)
                begin
                    state_next = ST_ROW;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_ROW: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sts.idx_last)
                begin
                    state_next = ST_DEQ;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.idx_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_EDGE_RD: cmd.edge_rd_a = 1'b1;
            ST_EDGE_WA: cmd.edge_wr_a = 1'b1;
            ST_EDGE_WB: cmd.edge_wr_b = 1'b1;
            ST_START:
            begin
                cmd.start   = 1'b1;
                cmd.idx_clr = 1'b1;
            end
            ST_DEQ:     cmd.deq = sts.queue_nonempty;
            ST_ROW:     cmd.row_rd = 1'b1;
            ST_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.idx_clr = sts.idx_last;
                cmd.idx_inc = !sts.idx_last;
            end
            ST_EMIT_RD: cmd.emit_rd = 1'b1;
            ST_EMIT_LD:
            begin
                cmd.emit_ld = sts.out_free;
                cmd.idx_clr = sts.out_free && sts.idx_last;
                cmd.idx_inc = sts.out_free && !sts.idx_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bhd_datapath.sv =====
`default_nettype none

module bhd_datapath #(
    parameter int NODE_LIMIT = bhd_pkg::NODE_LIMIT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bhd_pkg::COUNT_W-1:0]  cfg_data,
    input  wire logic                         kind,
    input  wire logic [bhd_pkg::NODE_W-1:0]   first_node,
    input  wire logic [bhd_pkg::NODE_W-1:0]   second_node,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic      [bhd_pkg::NODE_W-1:0]   node_index,
    output logic      [bhd_pkg::HOP_W-1:0]    hop_distance,
    output logic                              last,
    input  wire bhd_pkg::cmd_t                cmd,
    output bhd_pkg::sts_t                     sts
);

    import bhd_pkg::*;

    localparam int IW = $clog2(NODE_LIMIT);
    localparam int QW = IW + HOP_W;
    localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(NODE_LIMIT);
    localparam logic [NODE_LIMIT-1:0] BIT0 = NODE_LIMIT'(1);

    logic [COUNT_W-1:0]    node_count_reg;
    logic [COUNT_W-1:0]    cnt;
    logic [NODE_W-1:0]     a_reg;
    logic [NODE_W-1:0]     b_reg;
    logic [IW-1:0]         a_idx;
    logic [IW-1:0]         b_idx;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;
    logic [IW:0]           head_reg;
    logic [IW:0]           head_next;
    logic [IW:0]           tail_reg;
    logic [IW:0]           tail_next;
    logic [NODE_LIMIT-1:0] visited_reg;
    logic [NODE_LIMIT-1:0] visited_next;
    logic [NODE_LIMIT-1:0] adj_valid_reg;
    logic [NODE_LIMIT-1:0] adj_valid_next;
    logic                  row_valid_reg;
    logic                  row_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [NODE_W-1:0]     out_node_reg;
    logic [HOP_W-1:0]      out_hop_reg;
    logic                  out_last_reg;

    logic                  adj_we;
    logic [IW-1:0]         adj_waddr;
    logic [NODE_LIMIT-1:0] adj_wdata;
    logic                  adj_re;
    logic [IW-1:0]         adj_raddr;
    logic [NODE_LIMIT-1:0] adj_q;
    logic [NODE_LIMIT-1:0] row;

    logic                  q_we;
    logic [IW-1:0]         q_waddr;
    logic [QW-1:0]         q_wdata;
    logic                  q_re;
    logic [QW-1:0]         q_q;
    logic [IW-1:0]         q_node;
    logic [HOP_W-1:0]      q_dist;
    logic [HOP_W-1:0]      dist_inc;

    logic                  hop_we;
    logic [IW-1:0]         hop_waddr;
    logic [HOP_W-1:0]      hop_wdata;
    logic [HOP_W-1:0]      hop_q;

    logic                  hit;
    logic                  idx_last;

    assign cnt      = (node_count_reg > LIMIT_C) ? LIMIT_C : node_count_reg;
    assign a_idx    = a_reg[IW-1:0];
    assign b_idx    = b_reg[IW-1:0];
    assign row      = row_valid_reg ? adj_q : '0;
    assign q_node   = q_q[QW-1:HOP_W];
    assign q_dist   = q_q[HOP_W-1:0];
    assign dist_inc = q_dist + HOP_STEP;
    assign hit      = row[idx_reg] && !visited_reg[idx_reg];
    assign idx_last = (COUNT_W'(idx_reg) == (cnt - COUNT_W'(1)));

    always_comb
    begin
        sts.in_kind        = kind;
        sts.in_edge_ok     = (COUNT_W'(first_node) < cnt) && (COUNT_W'(second_node) < cnt);
        sts.start_ok       = (COUNT_W'(a_reg) < cnt);
        sts.queue_nonempty = (head_reg != tail_reg);
        sts.idx_last       = idx_last;
        sts.count_zero     = (cnt == '0);
        sts.out_free       = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        adj_we    = 1'b0;
        adj_waddr = a_idx;
        adj_wdata = row;
        adj_re    = 1'b0;
        adj_raddr = a_idx;
        if (cmd.edge_rd_a)
        begin
            adj_re = 1'b1;
        end
        if (cmd.edge_wr_a)
        begin
            adj_we    = 1'b1;
            adj_wdata = row | (BIT0 << b_idx);
            adj_re    = 1'b1;
            adj_raddr = b_idx;
        end
        if (cmd.edge_wr_b)
        begin
            adj_we    = (a_idx != b_idx);
            adj_waddr = b_idx;
            adj_wdata = row | (BIT0 << a_idx);
        end
        if (cmd.row_rd)
        begin
            adj_re    = 1'b1;
            adj_raddr = q_node;
        end
    end

    always_comb
    begin
        adj_valid_next = adj_valid_reg;
        if (adj_we)
        begin
            adj_valid_next[adj_waddr] = 1'b1;
        end
        row_valid_next = adj_re ? adj_valid_reg[adj_raddr] : row_valid_reg;
    end

    always_comb
    begin
        q_we         = 1'b0;
        q_waddr      = tail_reg[IW-1:0];
        q_wdata      = {idx_reg, dist_inc};
        q_re         = cmd.deq;
        hop_we       = 1'b0;
        hop_waddr    = idx_reg;
        hop_wdata    = dist_inc;
        head_next    = head_reg;
        tail_next    = tail_reg;
        visited_next = visited_reg;
        if (cmd.start)
        begin
            head_next    = '0;
            tail_next    = '0;
            visited_next = '0;
            if (sts.start_ok)
            begin
                q_we         = 1'b1;
                q_waddr      = '0;
                q_wdata      = {a_idx, HOP_ZERO};
                hop_we       = 1'b1;
                hop_waddr    = a_idx;
                hop_wdata    = HOP_ZERO;
                tail_next    = (IW+1)'(1);
                visited_next = BIT0 << a_idx;
            end
        end
        if (cmd.deq)
        begin
            head_next = head_reg + (IW+1)'(1);
        end
        if (cmd.scan && hit)
        begin
            q_we                  = 1'b1;
            hop_we                = 1'b1;
            tail_next             = tail_reg + (IW+1)'(1);
            visited_next[idx_reg] = 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IW'(1);
        end
        out_valid_next = out_valid_reg;
        if (cmd.emit_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            idx_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            visited_reg    <= '0;
            adj_valid_reg  <= '0;
            row_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            visited_reg   <= visited_next;
            adj_valid_reg <= adj_valid_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            a_reg <= first_node;
            b_reg <= second_node;
        end
        if (cmd.emit_ld)
        begin
            out_node_reg <= NODE_W'(idx_reg);
            out_hop_reg  <= visited_reg[idx_reg] ? hop_q : HOP_UNREACHED;
            out_last_reg <= idx_last;
        end
    end

    bhd_ram #(
        .WIDTH (NODE_LIMIT),
        .DEPTH (NODE_LIMIT)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_q)
    );

    bhd_ram #(
        .WIDTH (QW),
        .DEPTH (NODE_LIMIT)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg[IW-1:0]),
        .rdata (q_q)
    );

    bhd_ram #(
        .WIDTH (HOP_W),
        .DEPTH (NODE_LIMIT)
    ) u_hop_ram (
        .clk   (clk),
        .we    (hop_we),
        .waddr (hop_waddr),
        .wdata (hop_wdata),
        .re    (cmd.emit_rd),
        .raddr (idx_reg),
        .rdata (hop_q)
    );

    assign out_valid    = out_valid_reg;
    assign node_index   = out_node_reg;
    assign hop_distance = out_hop_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// ===== src/bfs_hop_distance.sv =====
`default_nettype none

// Breadth-first hop distances over an undirected graph of up to NODE_LIMIT nodes, held as a
// bit matrix in a RAM with one read and one write port, whose rows are marked empty at reset
// by per-row valid bits, so no clearing pass is needed. An edge word is accepted in the idle state
// and then goes through a row read and two row writes, set by the read-modify-write of two matrix
// rows through the single read port; an edge with an end out of range is accepted and dropped.
// A search word clears the queue and, if the start node is in range, seeds it with that node;
// each node taken from the queue costs a row read and then a scan of every candidate neighbour,
// and each of the N results, N being the node count in use, costs a RAM read and an output
// register load. Results leave through an output register, and the next input word may be
// accepted while the final result still waits.

module bfs_hop_distance #(
    parameter int NODE_LIMIT = bhd_pkg::NODE_LIMIT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic        [bhd_pkg::COUNT_W-1:0] cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              kind,
    input  wire logic        [bhd_pkg::NODE_W-1:0]  first_node,
    input  wire logic        [bhd_pkg::NODE_W-1:0]  second_node,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic             [bhd_pkg::NODE_W-1:0]  node_index,
    output logic signed      [bhd_pkg::HOP_W-1:0]   hop_distance,
    output logic                                   last
);

    import bhd_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [HOP_W-1:0] hop_raw;

    bhd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bhd_datapath #(
        .NODE_LIMIT (NODE_LIMIT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .first_node   (first_node),
        .second_node  (second_node),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .node_index   (node_index),
        .hop_distance (hop_raw),
        .last         (last),
        .cmd          (cmd),
        .sts          (sts)
    );

    assign hop_distance = $signed(hop_raw);

    // A result is loaded only when the output register is free or being emptied.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit_ld |-> sts.out_free)
        else $error("result loaded over an untaken word");

    // Whenever the block can take a word, the previous walk has drained its queue.
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !sts.queue_nonempty)
        else $error("work queue not empty while idle");

    // Loading the final result of a search returns the block to accepting words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ld && sts.idx_last) |=> in_ready)
        else $error("block did not return to idle after the final result");

endmodule

`default_nettype wire
